FILE: hw/rtl/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg: shared definitions for the nearest point table
// Field widths, table geometry, request and status codes, and the command
// and status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package npt_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 80;
  localparam int COORD_BITS  = 18;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Port field widths
  localparam int KIND_W      = 2;
  localparam int COORD_IN_W  = 18;
  localparam int TAG_W       = 16;
  localparam int STATUS_W    = 3;
  localparam int INDEX_OUT_W = 7;
  localparam int DIST_W      = 38;

  // Distance arithmetic: |a-b| <= 2^COORD_BITS, square <= 2^(2*COORD_BITS)
  localparam int MAG_W   = COORD_BITS + 1;
  localparam int SQ_W    = 2 * COORD_BITS + 1;
  localparam int SUM_W   = SQ_W + 1;
  localparam int ENTRY_W = 3 * COORD_BITS + TAG_W;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic                latch_query;
    logic                wr_en;
    logic                rd_en;
    logic                rd_first;
    logic [IDX_W-1:0]    addr;
    logic                load_result;
    logic [STATUS_W-1:0] res_status;
    logic [IDX_W-1:0]    res_index;
  } npt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_idle;
  } npt_stat_t;

endpackage

FILE: hw/rtl/npt_req_if.sv
// ----------------------------------------------------------------------------
// npt_req_if: request channel
// Valid/ready channel carrying one table operation per transaction.
// ----------------------------------------------------------------------------
interface npt_req_if import npt_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [KIND_W-1:0]     kind;
  logic signed [COORD_IN_W-1:0] x_coord;
  logic signed [COORD_IN_W-1:0] y_coord;
  logic signed [COORD_IN_W-1:0] z_coord;
  logic        [TAG_W-1:0]      name_tag;

  modport source (
    output valid, kind, x_coord, y_coord, z_coord, name_tag,
    input  ready
  );
  modport sink (
    input  valid, kind, x_coord, y_coord, z_coord, name_tag,
    output ready
  );
endinterface

FILE: hw/rtl/npt_rsp_if.sv
// ----------------------------------------------------------------------------
// npt_rsp_if: response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface npt_rsp_if import npt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [TAG_W-1:0]       found_tag;
  logic [INDEX_OUT_W-1:0] found_index;
  logic [DIST_W-1:0]      distance_sq;

  modport source (
    output valid, status, found_tag, found_index, distance_sq,
    input  ready
  );
  modport sink (
    input  valid, status, found_tag, found_index, distance_sq,
    output ready
  );
endinterface

FILE: hw/rtl/npt_ctrl.sv
// ----------------------------------------------------------------------------
// npt_ctrl: sequencer for the nearest point table
// Owns the entry count and the scan address, decodes requests and steers
// the datapath; holds the response valid flag.
// ----------------------------------------------------------------------------
module npt_ctrl import npt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [KIND_W-1:0] req_kind,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output npt_cmd_t          cmd,
  input  npt_stat_t         stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]          state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    rd_idx, rd_idx_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [IDX_W-1:0]    res_index, res_index_next;
  logic                rsp_valid_next;
  logic                accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_idx_next     = rd_idx;
    res_status_next = res_status;
    res_index_next  = res_index;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    cmd             = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_kind)
            KIND_ADD: begin
              state_next = S_RESP;
              if (count == CNT_W'(MAX_ENTRIES)) begin
                res_status_next = ST_FULL;
                res_index_next  = '0;
              end else begin
                cmd.wr_en       = 1'b1;
                cmd.addr        = count[IDX_W-1:0];
                res_status_next = ST_ADDED;
                res_index_next  = count[IDX_W-1:0];
                count_next      = count + CNT_W'(1);
              end
            end
            KIND_QUERY: begin
              res_index_next = '0;
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESP;
              end else begin
                cmd.latch_query = 1'b1;
                rd_idx_next     = '0;
                state_next      = S_SCAN;
              end
            end
            KIND_CLEAR: begin
              count_next      = '0;
              res_status_next = ST_CLEARED;
              res_index_next  = '0;
              state_next      = S_RESP;
            end
            default: begin
              state_next = S_IDLE;  // unused kind: dropped, no response
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.addr     = rd_idx;
        cmd.rd_first = (rd_idx == '0);
        if (CNT_W'(rd_idx) + CNT_W'(1) == count) begin
          res_status_next = ST_FOUND;
          state_next      = S_DRAIN;
        end else begin
          rd_idx_next = rd_idx + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (stat.pipe_idle) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_result = 1'b1;
          cmd.res_status  = res_status;
          cmd.res_index   = res_index;
          rsp_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_idx     <= '0;
      res_status <= ST_ADDED;
      res_index  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd_idx     <= rd_idx_next;
      res_status <= res_status_next;
      res_index  <= res_index_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

endmodule

FILE: hw/rtl/npt_datapath.sv
// ----------------------------------------------------------------------------
// npt_datapath: point memory and distance pipeline
// Entry memory with registered read, four-stage squared distance pipe,
// running minimum and the response register.
// ----------------------------------------------------------------------------
module npt_datapath import npt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  npt_cmd_t                     cmd,
  output npt_stat_t                    stat,
  input  logic signed [COORD_IN_W-1:0] x_coord,
  input  logic signed [COORD_IN_W-1:0] y_coord,
  input  logic signed [COORD_IN_W-1:0] z_coord,
  input  logic        [TAG_W-1:0]      name_tag,
  output logic        [STATUS_W-1:0]   status,
  output logic        [TAG_W-1:0]      found_tag,
  output logic        [INDEX_OUT_W-1:0] found_index,
  output logic        [DIST_W-1:0]     distance_sq
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic logic [MAG_W-1:0] abs_diff(coord_t a, coord_t b);
    logic signed [MAG_W-1:0] d;
    d = MAG_W'(a) - MAG_W'(b);
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  // entry layout: {tag, z, y, x}
  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

  coord_t qx, qy, qz;

  // stage 0: memory read
  logic [ENTRY_W-1:0] rd_data;
  logic               v0, f0;
  logic [IDX_W-1:0]   i0;
  // stage 1: per-axis magnitude
  logic [MAG_W-1:0]   ax, ay, az;
  logic               v1, f1;
  logic [IDX_W-1:0]   i1;
  logic [TAG_W-1:0]   t1;
  // stage 2: squares
  logic [SQ_W-1:0]    sx, sy, sz;
  logic               v2, f2;
  logic [IDX_W-1:0]   i2;
  logic [TAG_W-1:0]   t2;
  // stage 3: sum
  logic [SUM_W-1:0]   d3;
  logic               v3, f3;
  logic [IDX_W-1:0]   i3;
  logic [TAG_W-1:0]   t3;
  // running best
  logic [SUM_W-1:0]   best_d;
  logic [IDX_W-1:0]   best_i;
  logic [TAG_W-1:0]   best_tag;

  coord_t             px, py, pz;
  logic [2*MAG_W-1:0] prod_x, prod_y, prod_z;

  assign px = $signed(rd_data[COORD_BITS-1:0]);
  assign py = $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
  assign pz = $signed(rd_data[3*COORD_BITS-1:2*COORD_BITS]);

  assign prod_x = ax * ax;
  assign prod_y = ay * ay;
  assign prod_z = az * az;

  assign stat.pipe_idle = !(v0 || v1 || v2 || v3);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= {name_tag, COORD_BITS'(z_coord), COORD_BITS'(y_coord),
                        COORD_BITS'(x_coord)};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_query) begin
      qx <= coord_t'(x_coord);
      qy <= coord_t'(y_coord);
      qz <= coord_t'(z_coord);
    end
    f0 <= cmd.rd_first;
    i0 <= cmd.addr;

    ax <= abs_diff(px, qx);
    ay <= abs_diff(py, qy);
    az <= abs_diff(pz, qz);
    f1 <= f0;
    i1 <= i0;
    t1 <= rd_data[ENTRY_W-1:3*COORD_BITS];

    sx <= prod_x[SQ_W-1:0];
    sy <= prod_y[SQ_W-1:0];
    sz <= prod_z[SQ_W-1:0];
    f2 <= f1;
    i2 <= i1;
    t2 <= t1;

    d3 <= SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);
    f3 <= f2;
    i3 <= i2;
    t3 <= t2;

    // strict compare keeps the earliest entry on a tie
    if (v3 && (f3 || d3 < best_d)) begin
      best_d   <= d3;
      best_i   <= i3;
      best_tag <= t3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= cmd.rd_en;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status <= cmd.res_status;
      if (cmd.res_status == ST_FOUND) begin
        found_tag   <= best_tag;
        found_index <= INDEX_OUT_W'(best_i);
        distance_sq <= DIST_W'(best_d);
      end else begin
        found_tag   <= '0;
        found_index <= INDEX_OUT_W'(cmd.res_index);
        distance_sq <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/nearest_point_table.sv
// ----------------------------------------------------------------------------
// nearest_point_table: named 3-D point table with nearest neighbor search
// Stores up to MAX_ENTRIES points with name tags and answers nearest point
// queries by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage: each request transaction is one of add, query or clear, and each
// produces exactly one response transaction (an unused kind code is taken
// and dropped without a response). Add appends at the next free index and
// answers that index, or answers full when all MAX_ENTRIES slots are used.
// Clear resets the fill count only; old contents are never read again.
// Query walks entries 0..N-1 through a single-port memory, one read per
// cycle, into a four-stage distance pipe (magnitude, square, sum, compare);
// the earliest entry wins ties, and an empty table answers empty. A query
// answers once the memory read port has stepped through every stored entry
// and the pipe has drained. Requests are taken one at a time; a finished
// response sits in the output register while the next request is accepted.
// The memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module nearest_point_table import npt_pkg::*; (
  input logic       clk,
  input logic       rst,
  npt_req_if.sink   request,
  npt_rsp_if.source response
);

  npt_cmd_t  cmd;
  npt_stat_t stat;

  // Sequencer: decode, entry count, scan address, response valid
  npt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_kind  (request.kind),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Memory, distance pipe, running minimum, response register
  npt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .x_coord     (request.x_coord),
    .y_coord     (request.y_coord),
    .z_coord     (request.z_coord),
    .name_tag    (request.name_tag),
    .status      (response.status),
    .found_tag   (response.found_tag),
    .found_index (response.found_index),
    .distance_sq (response.distance_sq)
  );

  // A result is only captured once every scanned entry has left the pipe.
  a_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> stat.pipe_idle)
    else $error("result loaded while distance pipe busy");

  // No new request can slip in behind a memory read of the scan.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> !request.ready)
    else $error("request accepted during a scan");

  // Writes stay inside the table and never collide with a scan read.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (!cmd.rd_en && (32'(cmd.addr) < MAX_ENTRIES)))
    else $error("table write out of range or during read");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: nearest point table
// Adds, queries and clears go in over the request channel. A table model in
// this file works out each expected response, and every response transaction
// is checked field by field against the oldest one still waiting. Directed
// cases and random table builds and searches run across three
// back-pressure mixes.
// ----------------------------------------------------------------------------
module testbench;
  import npt_pkg::*;

  // Kind code with no meaning: taken and dropped, no response
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int C_MAX = (1 << (COORD_IN_W - 1)) - 1;
  localparam int C_MIN = -(1 << (COORD_IN_W - 1));

  // Idle cycles (nothing accepted on either side) before giving up. The limit
  // covers a full-table scan as well as long random stalls.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet time after the last response: longer than one full-table query
  localparam int DRAIN_CYCLES   = 100;

  typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGE} coord_spread_e;

  typedef struct {
    logic        [KIND_W-1:0]     kind;
    logic signed [COORD_IN_W-1:0] x_coord;
    logic signed [COORD_IN_W-1:0] y_coord;
    logic signed [COORD_IN_W-1:0] z_coord;
    logic        [TAG_W-1:0]      name_tag;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [TAG_W-1:0]       found_tag;
    logic [INDEX_OUT_W-1:0] found_index;
    logic [DIST_W-1:0]      distance_sq;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  npt_req_if req_ch ();
  npt_rsp_if rsp_ch ();

  nearest_point_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the table contents; only entries below table_fill are live
  int unsigned                 table_fill;
  logic signed [COORD_BITS-1:0] pt_x [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] pt_y [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] pt_z [MAX_ENTRIES];
  logic        [TAG_W-1:0]      pt_tag [MAX_ENTRIES];

  answer_t answer_queue [$];

  int req_idle_pct = 7;
  int rsp_idle_pct = 68;
  int items_sent;
  int unused_sent;
  int mismatches;
  int status_seen [5];

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Exact squared Euclidean distance from entry i to the query point
  function automatic logic [DIST_W-1:0] gap_sq(input int i, input request_t r);
    longint dx, dy, dz;
    dx = longint'(pt_x[i]) - longint'(r.x_coord);
    dy = longint'(pt_y[i]) - longint'(r.y_coord);
    dz = longint'(pt_z[i]) - longint'(r.z_coord);
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Applies one request to the table model; returns 0 when no response
  // is due (the unused kind code).
  function automatic bit table_predict(input request_t r, output answer_t a);
    logic [DIST_W-1:0] d, best_d;
    int best;
    bit produced;
    a = '0;
    produced = 1'b1;
    case (r.kind)
      KIND_ADD: begin
        if (table_fill >= MAX_ENTRIES) begin
          a.status = ST_FULL;
        end else begin
          pt_x[table_fill]   = r.x_coord;
          pt_y[table_fill]   = r.y_coord;
          pt_z[table_fill]   = r.z_coord;
          pt_tag[table_fill] = r.name_tag;
          a.status      = ST_ADDED;
          a.found_index = INDEX_OUT_W'(table_fill);
          table_fill++;
        end
      end
      KIND_QUERY: begin
        if (table_fill == 0) begin
          a.status = ST_EMPTY;
        end else begin
          best   = 0;
          best_d = gap_sq(0, r);
          // strict less-than: the earliest entry keeps a tie
          for (int i = 1; i < table_fill; i++) begin
            d = gap_sq(i, r);
            if (d < best_d) begin
              best_d = d;
              best   = i;
            end
          end
          a.status      = ST_FOUND;
          a.found_tag   = pt_tag[best];
          a.found_index = INDEX_OUT_W'(best);
          a.distance_sq = best_d;
        end
      end
      KIND_CLEAR: begin
        // stored data stays but is never read again
        table_fill = 0;
        a.status   = ST_CLEARED;
      end
      default: produced = 1'b0;
    endcase
    return produced;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Presents one request and returns at the edge where it is taken. valid
  // stays high on return, so back-to-back requests never toggle it in one step.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [COORD_IN_W-1:0] x,
                              input logic signed [COORD_IN_W-1:0] y,
                              input logic signed [COORD_IN_W-1:0] z,
                              input logic [TAG_W-1:0] tag);
    request_t r;
    answer_t  a;
    r.kind     = kind;
    r.x_coord  = x;
    r.y_coord  = y;
    r.z_coord  = z;
    r.name_tag = tag;
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.x_coord  <= x;
    req_ch.y_coord  <= y;
    req_ch.z_coord  <= z;
    req_ch.name_tag <= tag;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (table_predict(r, a)) begin
      answer_queue.push_back(a);
      items_sent++;
    end else begin
      unused_sent++;
    end
  endtask

  function automatic logic signed [COORD_IN_W-1:0] pick_coord(input coord_spread_e s);
    case (s)
      SPREAD_NARROW: return COORD_IN_W'(int'($urandom_range(31)) - 16);
      SPREAD_EDGE: begin
        case ($urandom_range(4))
          0:       return COORD_IN_W'(C_MIN);
          1:       return COORD_IN_W'(C_MAX);
          2:       return '0;
          3:       return '1;
          default: return COORD_IN_W'($urandom);
        endcase
      end
      default: return COORD_IN_W'($urandom);
    endcase
  endfunction

  task automatic add_random(input coord_spread_e s);
    send_request(KIND_ADD, pick_coord(s), pick_coord(s), pick_coord(s), TAG_W'($urandom));
  endtask

  // Half the time the query lands next to a live entry, so the winner is
  // a real neighbor and near-ties show up.
  task automatic query_random(input coord_spread_e s);
    int j;
    if (table_fill > 0 && $urandom_range(1)) begin
      j = $urandom_range(table_fill - 1);
      send_request(KIND_QUERY,
                   COORD_IN_W'(pt_x[j] + (int'($urandom_range(8)) - 4)),
                   COORD_IN_W'(pt_y[j] + (int'($urandom_range(8)) - 4)),
                   COORD_IN_W'(pt_z[j] + (int'($urandom_range(8)) - 4)),
                   TAG_W'($urandom));
    end else begin
      send_request(KIND_QUERY, pick_coord(s), pick_coord(s), pick_coord(s),
                   TAG_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure and the scoreboard
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    $display("tb: MISMATCH %s expected %0d got %0d (response %0d)",
             field, want, got, status_seen.sum());
    mismatches++;
  endtask

  always @(posedge clk) begin : check_response
    answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answer_queue.size() == 0) begin
        report_mismatch("unexpected response, status", 0, rsp_ch.status);
      end else begin
        want = answer_queue.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", want.status, rsp_ch.status);
        if (rsp_ch.found_tag !== want.found_tag)
          report_mismatch("found_tag", want.found_tag, rsp_ch.found_tag);
        if (rsp_ch.found_index !== want.found_index)
          report_mismatch("found_index", want.found_index, rsp_ch.found_index);
        if (rsp_ch.distance_sq !== want.distance_sq)
          report_mismatch("distance_sq", want.distance_sq, rsp_ch.distance_sq);
        if (want.status <= ST_CLEARED) status_seen[want.status]++;
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: timeout, %0d responses still due", answer_queue.size());
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Query and clear on a table that has never been written, plus the
  // unused kind code, which must produce nothing.
  task automatic test_empty_table();
    send_request(KIND_QUERY, COORD_IN_W'(C_MAX), '0, COORD_IN_W'(C_MIN), 16'hFFFF);
    send_request(KIND_CLEAR, '1, '1, '1, 16'hFFFF);
    send_request(KIND_UNUSED, '1, '1, '1, 16'hFFFF);
    send_request(KIND_QUERY, '0, '0, '0, '0);
  endtask

  // Corner coordinates, all-ones and all-zero tags, and the largest
  // possible distance (opposite corners of the cube).
  task automatic test_coord_extremes();
    send_request(KIND_ADD, COORD_IN_W'(C_MIN), COORD_IN_W'(C_MIN), COORD_IN_W'(C_MIN),
                 16'hFFFF);
    send_request(KIND_ADD, COORD_IN_W'(C_MAX), COORD_IN_W'(C_MAX), COORD_IN_W'(C_MAX),
                 16'h0000);
    send_request(KIND_QUERY, COORD_IN_W'(C_MAX), COORD_IN_W'(C_MAX), COORD_IN_W'(C_MAX),
                 '0);
    send_request(KIND_QUERY, COORD_IN_W'(C_MIN), COORD_IN_W'(C_MIN), COORD_IN_W'(C_MIN),
                 '0);
    send_request(KIND_QUERY, '0, '0, '0, '0);     // max entry is one unit closer
    send_request(KIND_QUERY, '1, '1, '1, '0);     // min entry is one unit closer
    send_request(KIND_CLEAR, '0, '0, '0, '0);
    send_request(KIND_ADD, COORD_IN_W'(C_MIN), COORD_IN_W'(C_MIN), COORD_IN_W'(C_MIN),
                 16'hAAAA);
    send_request(KIND_QUERY, COORD_IN_W'(C_MAX), COORD_IN_W'(C_MAX), COORD_IN_W'(C_MAX),
                 '0);
    send_request(KIND_ADD, COORD_IN_W'(C_MAX), COORD_IN_W'(C_MIN), '0, 16'h5555);
    send_request(KIND_QUERY, COORD_IN_W'(C_MIN), COORD_IN_W'(C_MAX), '0, '0);
  endtask

  // Equal distances: the lowest index must win
  task automatic test_ties();
    send_request(KIND_CLEAR, '0, '0, '0, '0);
    send_request(KIND_ADD, COORD_IN_W'(5), COORD_IN_W'(5), COORD_IN_W'(5), 16'h0101);
    send_request(KIND_ADD, COORD_IN_W'(5), COORD_IN_W'(5), COORD_IN_W'(5), 16'h0202);
    send_request(KIND_UNUSED, '0, '0, '0, 16'h0303);   // must not take a slot
    send_request(KIND_ADD, COORD_IN_W'(-5), COORD_IN_W'(-5), COORD_IN_W'(-5), 16'h0404);
    send_request(KIND_QUERY, '0, '0, '0, '0);
    send_request(KIND_ADD, COORD_IN_W'(1), '0, '0, 16'h0505);
    send_request(KIND_ADD, COORD_IN_W'(-1), '0, '0, 16'h0606);
    send_request(KIND_QUERY, '0, '0, '0, '0);
  endtask

  // Fill every slot, then overflow; the table must keep its contents
  task automatic test_table_full();
    coord_spread_e s;
    send_request(KIND_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      s = coord_spread_e'($urandom_range(2));
      add_random(s);
    end
    query_random(SPREAD_WIDE);
    for (int i = 0; i < 3; i++) add_random(SPREAD_WIDE);
    query_random(SPREAD_NARROW);
    query_random(SPREAD_EDGE);
    send_request(KIND_CLEAR, '0, '0, '0, '0);
    query_random(SPREAD_WIDE);
    add_random(SPREAD_EDGE);
    query_random(SPREAD_WIDE);
  endtask

  // Mostly table builds with interleaved searches; now and then a long
  // build that runs into the full table. The rest is loose noise,
  // unused kind codes among it.
  task automatic run_random_mix(input int n_items);
    int stop_at, adds, queries;
    coord_spread_e s;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 7) begin
        s = coord_spread_e'($urandom_range(2));
        if ($urandom_range(1) || table_fill > 60)
          send_request(KIND_CLEAR, COORD_IN_W'($urandom), COORD_IN_W'($urandom),
                       COORD_IN_W'($urandom), TAG_W'($urandom));
        adds    = ($urandom_range(9) == 0) ? $urandom_range(40, 84) : $urandom_range(1, 8);
        queries = $urandom_range(1, 4);
        while (adds + queries > 0) begin
          if (queries == 0 || (adds > 0 && $urandom_range(2) != 0)) begin
            add_random(s);
            adds--;
          end else begin
            query_random(s);
            queries--;
          end
        end
      end else begin
        send_request(KIND_W'($urandom_range(3)), COORD_IN_W'($urandom),
                     COORD_IN_W'($urandom), COORD_IN_W'($urandom), TAG_W'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.kind     = KIND_ADD;
    req_ch.x_coord  = '0;
    req_ch.y_coord  = '0;
    req_ch.z_coord  = '0;
    req_ch.name_tag = '0;
    rsp_ch.ready    = 1'b0;
    table_fill      = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender mostly busy, receiver stalling hard
    req_idle_pct = 7;
    rsp_idle_pct = 68;
    test_empty_table();
    test_coord_extremes();
    test_ties();
    run_random_mix(110);

    // Phase 2: sender gappy, receiver mostly ready
    req_idle_pct = 68;
    rsp_idle_pct = 7;
    test_table_full();
    run_random_mix(110);

    // Phase 3: full rate both ways
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    run_random_mix(110);

    req_ch.valid <= 1'b0;
    while (answer_queue.size() != 0) @(posedge clk);
    // any stray response after the last expected one is caught here
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests checked: %0d added, %0d full, %0d found, %0d empty, %0d cleared",
             items_sent, status_seen[ST_ADDED], status_seen[ST_FULL],
             status_seen[ST_FOUND], status_seen[ST_EMPTY], status_seen[ST_CLEARED]);
    $display("tb: %0d unused kind codes dropped, %0d mismatches", unused_sent, mismatches);
    if (mismatches == 0 && answer_queue.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/npt_pkg.sv
hw/rtl/npt_req_if.sv
hw/rtl/npt_rsp_if.sv
hw/rtl/npt_ctrl.sv
hw/rtl/npt_datapath.sv
hw/rtl/nearest_point_table.sv
tb/testbench.sv
